// ===== hdl/ctav_pkg.sv =====
// Shared types and constants for the cluster template averager.
// Item payloads, controller command and status groups, store geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctav_pkg;

    localparam int CLUSTERS_MAX         = 64;
    localparam int SAMPLES_PER_CLIP_MAX = 256;
    localparam int SAMPLE_BITS          = 16;

    localparam int MODE_W    = 2;
    localparam int LABEL_W   = 7;
    localparam int POS_W     = 8;
    localparam int SUM_W     = 40;
    localparam int COUNT_W   = 20;
    localparam int CLUSTER_W = $clog2(CLUSTERS_MAX);
    localparam int SUM_DEPTH = CLUSTERS_MAX * SAMPLES_PER_CLIP_MAX;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);

    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic [LABEL_W-1:0]            label;
        logic [POS_W-1:0]              position;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clip_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          cluster_empty;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic acc_write;
        logic div_start;
        logic out_load;
    } ctav_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              slot_ok;
        logic              sweep_last;
        logic              div_done;
        logic              out_free;
    } ctav_status_t;

endpackage

`default_nettype wire

// ===== hdl/cluster_template_averager_core.sv =====
// Per-cluster mean template accumulator. Accumulate beats are written back in the
// execute state. A read beat runs the 40-step divider; no new beat is accepted until
// its result is loaded, which waits while an earlier result still waits for m_ready.
// Reset and clear beats sweep all 16384 sum entries, zeroing every sum and count;
// no beat is accepted during the sweep. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module cluster_template_averager_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ctav_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ctav_pkg::out_item_t       m_data
);

    ctav_pkg::ctav_cmd_t    cmd;
    ctav_pkg::ctav_status_t status;

    ctav_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .status  (status),
        .cmd     (cmd)
    );

    ctav_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== hdl/ctav_divider.sv =====
// Restoring divider: signed sum by unsigned clip count, one quotient bit a cycle.
// Quotient truncates toward zero and saturates to the sample range.
// Depends on ctav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctav_divider (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        start,
    input  wire logic signed [ctav_pkg::SUM_W-1:0]           dividend,
    input  wire logic [ctav_pkg::COUNT_W-1:0]                divisor,
    output logic                                             done,
    output logic signed [ctav_pkg::SAMPLE_BITS-1:0]          quotient
);

    localparam int SUM_W    = ctav_pkg::SUM_W;
    localparam int COUNT_W  = ctav_pkg::COUNT_W;
    localparam int SMP_W    = ctav_pkg::SAMPLE_BITS;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);
    localparam logic [SUM_W-1:0]  MAG_MAX   = SUM_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [SMP_W-1:0] AVG_MAX = {1'b0, {(SMP_W - 1){1'b1}}};
    localparam logic signed [SMP_W-1:0] AVG_MIN = {1'b1, {(SMP_W - 1){1'b0}}};

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [COUNT_W-1:0]  div_reg, div_next;
    logic                neg_reg, neg_next;

    logic [COUNT_W:0]    trial;
    logic [COUNT_W:0]    diff;
    logic                fits;

    always_comb begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // clamp the magnitude to the sample range, then restore the sign
    always_comb begin
        if (quo_reg > MAG_MAX) begin
            quotient = neg_reg ? AVG_MIN : AVG_MAX;
        end else if (neg_reg) begin
            quotient = SMP_W'(-quo_reg[SMP_W-1:0]);
        end else begin
            quotient = SMP_W'(quo_reg[SMP_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/ctav_datapath.sv =====
// Datapath: sum and count stores, saturating accumulate, clearing sweep,
// divider and output register. Depends on ctav_pkg and ctav_divider.
`timescale 1ns / 1ps
`default_nettype none

module ctav_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctav_pkg::in_item_t    s_data,
    input  wire ctav_pkg::ctav_cmd_t   cmd,
    output ctav_pkg::ctav_status_t     status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ctav_pkg::out_item_t        m_data
);

    localparam int SUM_W     = ctav_pkg::SUM_W;
    localparam int COUNT_W   = ctav_pkg::COUNT_W;
    localparam int ADDR_W    = ctav_pkg::ADDR_W;
    localparam int CLUSTER_W = ctav_pkg::CLUSTER_W;
    localparam int LABEL_W   = ctav_pkg::LABEL_W;
    localparam int POS_W     = ctav_pkg::POS_W;
    localparam int SMP_W     = ctav_pkg::SAMPLE_BITS;
    localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(ctav_pkg::SUM_DEPTH - 1);
    localparam logic [ADDR_W-1:0]  CNT_ROWS   = ADDR_W'(ctav_pkg::CLUSTERS_MAX);
    localparam logic [SUM_W-1:0]   SUM_MAX    = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic [SUM_W-1:0]   SUM_MIN    = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    function automatic logic [CLUSTER_W-1:0] row_of(input logic [LABEL_W-1:0] label);
        row_of = CLUSTER_W'(label - LABEL_W'(1));
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LABEL_W-1:0] label,
                                                 input logic [POS_W-1:0]   position);
        addr_of = ADDR_W'(row_of(label)) * ADDR_W'(ctav_pkg::SAMPLES_PER_CLIP_MAX)
                + ADDR_W'(position);
    endfunction

    logic [SUM_W-1:0]   sum_mem [ctav_pkg::SUM_DEPTH];
    logic [COUNT_W-1:0] cnt_mem [ctav_pkg::CLUSTERS_MAX];

    ctav_pkg::in_item_t item_reg;
    logic [ADDR_W-1:0]  sweep_cnt_reg;
    logic [SUM_W-1:0]   sum_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic               empty_reg;
    logic               m_valid_reg;
    ctav_pkg::out_item_t m_data_reg;

    logic               slot_ok;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               cnt_bump;
    logic               out_free;
    logic               div_done;
    logic signed [SMP_W-1:0] div_q;

    assign slot_ok = (item_reg.label != '0)
                  && (item_reg.label <= LABEL_W'(ctav_pkg::CLUSTERS_MAX))
                  && ({1'b0, item_reg.position} < (POS_W + 1)'(ctav_pkg::SAMPLES_PER_CLIP_MAX));

    always_comb begin
        sum_wide = {sum_rd_reg[SUM_W-1], sum_rd_reg}
                 + {{(SUM_W + 1 - SMP_W){item_reg.sample[SMP_W-1]}}, item_reg.sample};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign cnt_bump = item_reg.clip_end && (cnt_rd_reg != COUNT_MAX);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
    end

    // zero one sum entry a cycle; the count rows are zeroed along with the first 64 entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep) begin
            sweep_cnt_reg <= (sweep_cnt_reg == SWEEP_LAST) ? '0 : sweep_cnt_reg + ADDR_W'(1);
        end
    end

    // stores are read every cycle at the address on the input channel
    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            sum_mem[sweep_cnt_reg] <= '0;
        end else if (cmd.acc_write) begin
            sum_mem[addr_of(item_reg.label, item_reg.position)] <= sum_sat;
        end
        sum_rd_reg <= sum_mem[addr_of(s_data.label, s_data.position)];
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            if (sweep_cnt_reg < CNT_ROWS) begin
                cnt_mem[sweep_cnt_reg[CLUSTER_W-1:0]] <= '0;
            end
        end else if (cmd.acc_write && cnt_bump) begin
            cnt_mem[row_of(item_reg.label)] <= cnt_rd_reg + COUNT_W'(1);
        end
        cnt_rd_reg <= cnt_mem[row_of(s_data.label)];
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            empty_reg <= !(slot_ok && (cnt_rd_reg != '0));
        end
    end

    ctav_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_rd_reg),
        .divisor  (cnt_rd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.average       <= empty_reg ? '0 : div_q;
            m_data_reg.cluster_empty <= empty_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status.mode       = item_reg.mode;
        status.slot_ok    = slot_ok;
        status.sweep_last = (sweep_cnt_reg == SWEEP_LAST);
        status.div_done   = div_done;
        status.out_free   = out_free;
    end

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.sweep && cmd.acc_write))
        else $error("sweep and accumulate write collide");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an unaccepted beat");

    a_write_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc_write |-> slot_ok)
        else $error("accumulate write to an invalid slot");

    a_sweep_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep && (sweep_cnt_reg == SWEEP_LAST)) |=> (sweep_cnt_reg == '0))
        else $error("sweep counter did not wrap");

endmodule

`default_nettype wire

// ===== hdl/ctav_ctrl.sv =====
// Controller state machine: clearing sweep, accept, accumulate, divide, respond.
// Drives the datapath through ctav_cmd_t. Depends on ctav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctav_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [ctav_pkg::MODE_W-1:0] s_mode,
    input  wire ctav_pkg::ctav_status_t   status,
    output ctav_pkg::ctav_cmd_t           cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (s_mode) inside
                        ctav_pkg::MODE_ACC,
                        ctav_pkg::MODE_READ:  state_next = ST_EXEC;
                        ctav_pkg::MODE_CLEAR: state_next = ST_CLEAR;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                // store read data for the captured beat is valid here
                if (status.mode == ctav_pkg::MODE_READ) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.acc_write = status.slot_ok;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/cluster_template_averager_core_test.sv =====
// Self-checking test of cluster_template_averager_core: a directed table, then random
// labelled clips, reads and clears, checked against a built-in template predictor.
// Depends on ctav_pkg and the core RTL only.
`timescale 1ns / 1ps

module cluster_template_averager_core_test;

    localparam int MODE_W               = ctav_pkg::MODE_W;
    localparam int LABEL_W              = ctav_pkg::LABEL_W;
    localparam int POS_W                = ctav_pkg::POS_W;
    localparam int SUM_W                = ctav_pkg::SUM_W;
    localparam int COUNT_W              = ctav_pkg::COUNT_W;
    localparam int SAMPLE_BITS          = ctav_pkg::SAMPLE_BITS;
    localparam int SUM_DEPTH            = ctav_pkg::SUM_DEPTH;
    localparam int CLUSTERS_MAX         = ctav_pkg::CLUSTERS_MAX;
    localparam int SAMPLES_PER_CLIP_MAX = ctav_pkg::SAMPLES_PER_CLIP_MAX;
    localparam int NOISE_W              = $bits(ctav_pkg::in_item_t);

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int      RAND_ITEMS  = 700;
    localparam int      QUIET_ITEMS = 100;
    localparam int      DRAIN_CYCLES = 200;
    localparam longint  SUM_TOP    = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint  SUM_BOTTOM = -SUM_TOP - 1;
    localparam longint  AVG_TOP    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint  AVG_BOTTOM = -AVG_TOP - 1;

    typedef struct packed {
        ctav_pkg::in_item_t  beat;
        logic                typed;
        ctav_pkg::out_item_t result;
    } stim_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ctav_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ctav_pkg::out_item_t m_data;

    // template predictor state
    logic signed [SUM_W-1:0] sum_model   [SUM_DEPTH];
    logic [COUNT_W-1:0]      clips_model [CLUSTERS_MAX];

    ctav_pkg::out_item_t average_q [$];
    ctav_pkg::out_item_t oldest;
    stim_row_t directed_rows [$];

    int  errors       = 0;
    int  reads_seen   = 0;
    int  clips_sent   = 0;
    int  clears_sent  = 0;
    int  rand_beats   = 0;
    int  stall_left   = 0;
    bit  quiet        = 1'b0;

    cluster_template_averager_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic clear_templates();
        for (int i = 0; i < SUM_DEPTH; i++) sum_model[i] = '0;
        for (int k = 0; k < CLUSTERS_MAX; k++) clips_model[k] = '0;
    endtask

    task automatic compute_template(input ctav_pkg::in_item_t it, output bit has_res,
                                    output ctav_pkg::out_item_t res);
        longint acc;
        longint quot;
        int     k;
        int     slot;
        bit     slot_ok;
        has_res = 1'b0;
        res     = '0;
        slot_ok = it.label >= 1 && it.label <= CLUSTERS_MAX &&
                  int'(it.position) < SAMPLES_PER_CLIP_MAX;
        k    = int'(it.label) - 1;
        slot = k * SAMPLES_PER_CLIP_MAX + int'(it.position);
        case (it.mode)
            ctav_pkg::MODE_ACC: begin
                if (slot_ok) begin
                    acc = longint'(sum_model[slot]) + longint'(it.sample);
                    if (acc > SUM_TOP) acc = SUM_TOP;
                    if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
                    sum_model[slot] = acc[SUM_W-1:0];
                    if (it.clip_end && clips_model[k] != '1)
                        clips_model[k] = clips_model[k] + 1'b1;
                end
            end
            ctav_pkg::MODE_READ: begin
                has_res = 1'b1;
                res.cluster_empty = 1'b1;
                if (slot_ok && clips_model[k] != '0) begin
                    quot = longint'(sum_model[slot]) / longint'(clips_model[k]);
                    if (quot > AVG_TOP) quot = AVG_TOP;
                    if (quot < AVG_BOTTOM) quot = AVG_BOTTOM;
                    res.average       = quot[SAMPLE_BITS-1:0];
                    res.cluster_empty = 1'b0;
                end
            end
            ctav_pkg::MODE_CLEAR: clear_templates();
            default: ;
        endcase
    endtask

    function automatic stim_row_t row(input logic [MODE_W-1:0] mode, input int label,
                                      input int position, input int sample, input bit ce,
                                      input bit typed, input int avg, input bit empty);
        stim_row_t r;
        r.beat.mode     = mode;
        r.beat.label    = LABEL_W'(label);
        r.beat.position = POS_W'(position);
        r.beat.sample   = SAMPLE_BITS'(sample);
        r.beat.clip_end = ce;
        r.typed                = typed;
        r.result.average       = SAMPLE_BITS'(avg);
        r.result.cluster_empty = empty;
        return r;
    endfunction

    function automatic ctav_pkg::in_item_t mk_beat(input logic [MODE_W-1:0] mode,
                                                   input int label, input int position,
                                                   input int sample, input bit ce);
        ctav_pkg::in_item_t b;
        b.mode     = mode;
        b.label    = LABEL_W'(label);
        b.position = POS_W'(position);
        b.sample   = SAMPLE_BITS'(sample);
        b.clip_end = ce;
        return b;
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 3))
            0, 1:    return int'($signed(16'($urandom)));
            2:       return $urandom_range(0, 200) - 100;
            default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        endcase
    endfunction

    function automatic int pick_cluster();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 4);
        if (r == 7) return CLUSTERS_MAX;
        return $urandom_range(5, CLUSTERS_MAX - 1);
    endfunction

    // Present one beat at the falling edge and hold it until the handshake.
    task automatic issue(input ctav_pkg::in_item_t it, input bit typed,
                         input ctav_pkg::out_item_t typed_res);
        bit                  has_res;
        ctav_pkg::out_item_t res;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        compute_template(it, has_res, res);
        if (has_res) average_q.push_back(typed ? typed_res : res);
        if (it.mode == ctav_pkg::MODE_CLEAR) clears_sent++;
    endtask

    task automatic wait_drained();
        while (average_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: stall in random bursts, no new bursts once the run goes quiet.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reads_seen++;
            if (average_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, got average %0d empty %0b",
                         $time, $signed(m_data.average), m_data.cluster_empty);
            end else begin
                oldest = average_q.pop_front();
                if (m_data.average !== oldest.average ||
                    m_data.cluster_empty !== oldest.cluster_empty) begin
                    errors++;
                    $display("%0t: mismatch: expected average %0d empty %0b, got average %0d empty %0b",
                             $time, $signed(oldest.average), oldest.cluster_empty,
                             $signed(m_data.average), m_data.cluster_empty);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int                 len;
        int                 base;
        int                 cluster;
        int                 pick;
        bit                 broken;
        bit                 drained_once;
        ctav_pkg::in_item_t noise;
        drained_once = 1'b0;
        clear_templates();

        directed_rows = '{
            row(ctav_pkg::MODE_READ,    1,   0,      0, 0, 1,      0, 1),
            row(ctav_pkg::MODE_READ,    0,   0,      0, 0, 1,      0, 1),
            row(ctav_pkg::MODE_READ,   65,   3,      0, 0, 1,      0, 1),
            row(ctav_pkg::MODE_READ,  127, 255,     -1, 1, 1,      0, 1),
            row(ctav_pkg::MODE_ACC,     1,   0,  32767, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    1,   0,      0, 0, 1,  32767, 0),
            row(ctav_pkg::MODE_ACC,    64, 255, -32768, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,   64, 255,      0, 0, 1, -32768, 0),
            row(ctav_pkg::MODE_ACC,     0,   0,    100, 1, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,   100,   1,    100, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    1,   0,      0, 0, 1,  32767, 0),
            row(MODE_SPARE,             1,   0,      5, 1, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     2,   5,  32767, 0, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     2,   5,  32767, 0, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     2,   5,  32767, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    2,   5,      0, 0, 1,  32767, 0),
            row(ctav_pkg::MODE_ACC,     3,   7, -32768, 0, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     3,   7, -32768, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    3,   7,      0, 0, 1, -32768, 0),
            row(ctav_pkg::MODE_ACC,     4,   0,     -7, 0, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     4,   1,      0, 1, 0,      0, 0),
            row(ctav_pkg::MODE_ACC,     4,   0,      0, 1, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    4,   0,      0, 0, 0,      0, 0),
            row(ctav_pkg::MODE_CLEAR,   0,   0,      0, 0, 0,      0, 0),
            row(ctav_pkg::MODE_READ,    1,   0,      0, 0, 1,      0, 1)
        };

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

        while (rand_beats < RAND_ITEMS) begin
            quiet = (rand_beats >= RAND_ITEMS - QUIET_ITEMS);
            if (!drained_once && rand_beats >= RAND_ITEMS / 2) begin
                // hold the sender until every read has come back
                @(negedge aclk);
                s_valid = 1'b0;
                wait_drained();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // a clip; about one in seven leaves its last sample without the clip end mark
                cluster = pick_cluster();
                len     = $urandom_range(1, 6);
                base    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 256 - len) : 0;
                broken  = ($urandom_range(0, 6) == 0);
                for (int p = 0; p < len; p++) begin
                    issue(mk_beat(ctav_pkg::MODE_ACC, cluster, base + p, pick_sample(),
                                  !broken && p == len - 1), 1'b0, '0);
                    rand_beats++;
                end
                clips_sent++;
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    cluster = ($urandom_range(0, 6) != 0) ? pick_cluster()
                                                          : $urandom_range(0, 127);
                    base    = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(0, 255);
                    issue(mk_beat(ctav_pkg::MODE_READ, cluster, base, pick_sample(),
                                  $urandom_range(0, 1)), 1'b0, '0);
                    rand_beats++;
                end
            end else if (pick < 99 || clears_sent >= 4) begin
                // noise: any field value, but leave clearing to its own branch
                noise = ctav_pkg::in_item_t'(NOISE_W'({$urandom, $urandom}));
                if (noise.mode == ctav_pkg::MODE_CLEAR) noise.mode = MODE_SPARE;
                issue(noise, 1'b0, '0);
            end else begin
                issue(mk_beat(ctav_pkg::MODE_CLEAR, 0, 0, 0, 0), 1'b0, '0);
                rand_beats++;
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d directed and %0d random beats: %0d clips, %0d clears, %0d reads checked.",
                 directed_rows.size(), rand_beats, clips_sent, clears_sent, reads_seen);
        $display("%0d mismatches found.", errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
